// ===== sv/mxu_pkg.sv =====
// Shared types, codes and helpers of the micro-op execute unit.
package mxu_pkg;

    localparam int RAM_AW    = 16;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int DATA_W    = 8;

    localparam logic [1:0] FLAGS_LOGIC = 2'(3);

    typedef enum logic [4:0] {
        OP_NOP  = 5'd0,
        OP_IMM  = 5'd1,
        OP_MOVA = 5'd2,
        OP_MOVB = 5'd3,
        OP_ADD  = 5'd4,
        OP_ADDC = 5'd5,
        OP_SUB  = 5'd6,
        OP_SUBC = 5'd7,
        OP_AND  = 5'd8,
        OP_OR   = 5'd9,
        OP_XOR  = 5'd10,
        OP_SHL  = 5'd11,
        OP_SHLC = 5'd12,
        OP_NOTA = 5'd13,
        OP_NOTB = 5'd14,
        OP_CMP  = 5'd15,
        OP_STA  = 5'd16,
        OP_STB  = 5'd17,
        OP_STI  = 5'd18,
        OP_LD   = 5'd19,
        OP_B    = 5'd20,
        OP_OUTI = 5'd21
    } op_t;

    typedef enum logic [2:0] {
        SEL_INSTR   = 3'd0,
        SEL_A       = 3'd1,
        SEL_B       = 3'd2,
        SEL_ADDR_LO = 3'd3,
        SEL_ADDR_HI = 3'd4
    } sel_t;

    typedef enum logic [7:0] {
        PORT_ZERO = 8'd0,
        PORT_ONE  = 8'd1
    } port_sel_t;

    typedef struct packed {
        logic [7:0]  instr;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  addr_lo;
        logic [7:0]  addr_hi;
        logic [1:0]  flags;
        logic [15:0] pc;
        logic [7:0]  step;
        logic [7:0]  port0;
        logic [7:0]  port1;
    } arch_t;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wdata;
    } mem_req_t;

    function automatic arch_t write_target(arch_t s, logic [2:0] sel, logic [7:0] val);
        arch_t r;
        r = s;
        case (sel)
            SEL_INSTR:   r.instr   = val;
            SEL_A:       r.a       = val;
            SEL_B:       r.b       = val;
            SEL_ADDR_LO: r.addr_lo = val;
            SEL_ADDR_HI: r.addr_hi = val;
            default:     r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/mxu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mxu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mxu_exec.sv =====
// Combinational execute logic: next register state, memory request and fault for one micro-op.
module mxu_exec (
    input  mxu_pkg::arch_t    cur,
    input  logic              edge_req,
    input  logic [4:0]        micro_op,
    input  logic [2:0]        target_select,
    input  logic              step_keep,
    input  logic [7:0]        rom_byte,
    output mxu_pkg::arch_t    nxt,
    output mxu_pkg::mem_req_t req,
    output logic              fault
);

    logic       writes;
    logic       bad_sel;
    logic       is_sub;
    logic       cin;
    logic [7:0] bop;
    logic [8:0] sum;
    logic [1:0] arith_flags;

    always_comb
    begin
        writes  = ((micro_op >= mxu_pkg::OP_IMM) && (micro_op <= mxu_pkg::OP_NOTB))
                  || (micro_op == mxu_pkg::OP_LD);
        bad_sel = target_select > mxu_pkg::SEL_ADDR_HI;
        is_sub  = (micro_op == mxu_pkg::OP_SUB) || (micro_op == mxu_pkg::OP_SUBC)
                  || (micro_op == mxu_pkg::OP_CMP);
        cin     = (micro_op == mxu_pkg::OP_ADDC) || (micro_op == mxu_pkg::OP_SUB)
                  || (micro_op == mxu_pkg::OP_CMP);
        bop     = is_sub ? ~cur.b : cur.b;
        sum     = {1'b0, cur.a} + {1'b0, bop} + 9'(cin);
        arith_flags = {(sum[7:0] == 8'd0), ~sum[8]};

        nxt   = cur;
        req   = '0;
        fault = 1'b0;

        if (edge_req)
        begin
            nxt.step = step_keep ? cur.step + 8'd1 : 8'd0;
            unique case (micro_op)
                mxu_pkg::OP_IMM, mxu_pkg::OP_STI, mxu_pkg::OP_OUTI: nxt.pc = cur.pc + 16'd1;
                mxu_pkg::OP_B: nxt.pc = {cur.addr_hi, cur.addr_lo};
                default: nxt.pc = cur.pc;
            endcase
        end
        else if (writes && bad_sel)
        begin
            fault = 1'b1;
        end
        else
        begin
            unique case (micro_op)
                mxu_pkg::OP_IMM:  nxt = mxu_pkg::write_target(cur, target_select, rom_byte);
                mxu_pkg::OP_MOVA: nxt = mxu_pkg::write_target(cur, target_select, cur.a);
                mxu_pkg::OP_MOVB: nxt = mxu_pkg::write_target(cur, target_select, cur.b);
                mxu_pkg::OP_ADD, mxu_pkg::OP_ADDC, mxu_pkg::OP_SUB, mxu_pkg::OP_SUBC:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, sum[7:0]);
                    nxt.flags = arith_flags;
                end
                mxu_pkg::OP_CMP:  nxt.flags = arith_flags;
                mxu_pkg::OP_AND:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, cur.a & cur.b);
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_OR:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, cur.a | cur.b);
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_XOR:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, cur.a ^ cur.b);
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_SHL:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, {cur.a[6:0], 1'b0});
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_SHLC:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select,
                                                {cur.a[6:0], cur.flags[0]});
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_NOTA:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, ~cur.a);
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_NOTB:
                begin
                    nxt = mxu_pkg::write_target(cur, target_select, ~cur.b);
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_STA:
                begin
                    req.wr_en = 1'b1;
                    req.wdata = cur.a;
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_STB:
                begin
                    req.wr_en = 1'b1;
                    req.wdata = cur.b;
                    nxt.flags = mxu_pkg::FLAGS_LOGIC;
                end
                mxu_pkg::OP_STI:
                begin
                    req.wr_en = 1'b1;
                    req.wdata = rom_byte;
                end
                mxu_pkg::OP_LD:   req.rd_en = 1'b1;
                mxu_pkg::OP_OUTI:
                begin
                    if (cur.addr_lo == mxu_pkg::PORT_ZERO)
                    begin
                        nxt.port0 = rom_byte;
                    end
                    else if (cur.addr_lo == mxu_pkg::PORT_ONE)
                    begin
                        nxt.port1 = rom_byte;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                default: nxt = cur;
            endcase
        end
    end

endmodule

// ===== sv/microop_execute_unit.sv =====
// Top level of the micro-op execute unit: register state, data RAM and result stage.
//
// The input channel (in_valid/in_ready) carries one micro-op transaction per clock
// edge of the emulated CPU; the output channel (out_valid/out_ready) returns one
// transaction per input with the full visible register state after that step and
// a fault bit. Results appear in order; an accepted input passes the read stage
// (s1) and then the output register. Throughput is one transaction per cycle,
// loads included, while out_ready stays high: a load reads the data RAM (registered
// read) and its data is forwarded to the register state seen by the next micro-op.
// After reset the unit runs a clearing pass over the data RAM, writing zero to one
// entry per cycle, so in_ready stays low until all RAM_DEPTH (65536) entries are
// cleared. When the receiver stalls, the result stays in the output register and
// the unit holds one more micro-op in flight; beyond that in_ready drops.
module microop_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        edge_req,
    input  logic [4:0]  micro_op,
    input  logic [2:0]  target_select,
    input  logic        step_keep,
    input  logic [7:0]  rom_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  instr_value,
    output logic [7:0]  a_value,
    output logic [7:0]  b_value,
    output logic [7:0]  addr_low,
    output logic [7:0]  addr_high,
    output logic [1:0]  flag_bits,
    output logic [15:0] pc_value,
    output logic [7:0]  step_value,
    output logic [7:0]  port_zero,
    output logic [7:0]  port_one,
    output logic        fault
);

    mxu_pkg::arch_t    regs_reg;
    mxu_pkg::arch_t    regs_next;
    mxu_pkg::arch_t    eff;
    mxu_pkg::arch_t    exec_nxt;
    mxu_pkg::arch_t    out_state_reg;
    mxu_pkg::mem_req_t req;
    logic              exec_fault;

    logic                       clearing_reg;
    logic [mxu_pkg::RAM_AW-1:0] clear_cnt_reg;

    logic       s1_valid_reg;
    logic       s1_ld_reg;
    logic [2:0] s1_sel_reg;
    logic       s1_fault_reg;
    logic       out_valid_reg;
    logic       out_fault_reg;

    logic                       accept;
    logic                       s1_adv;
    logic [mxu_pkg::RAM_AW-1:0] ram_addr;
    logic [7:0]                 ram_rdata;
    logic                       ram_we;
    logic [mxu_pkg::RAM_AW-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;

    // The pending load result overrides its target register until committed.
    always_comb
    begin
        eff = s1_ld_reg ? mxu_pkg::write_target(regs_reg, s1_sel_reg, ram_rdata) : regs_reg;
    end

    mxu_exec u_exec (
        .cur           (eff),
        .edge_req      (edge_req),
        .micro_op      (micro_op),
        .target_select (target_select),
        .step_keep     (step_keep),
        .rom_byte      (rom_byte),
        .nxt           (exec_nxt),
        .req           (req),
        .fault         (exec_fault)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    assign ram_addr  = mxu_pkg::RAM_AW'({eff.addr_hi, eff.addr_lo});
    assign ram_we    = clearing_reg || (accept && req.wr_en);
    assign ram_waddr = clearing_reg ? clear_cnt_reg : ram_addr;
    assign ram_wdata = clearing_reg ? 8'd0 : req.wdata;
    assign ram_re    = accept && req.rd_en;

    mxu_ram #(
        .WIDTH (mxu_pkg::DATA_W),
        .DEPTH (mxu_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (accept)
        begin
            regs_next = exec_nxt;
        end
        else if (s1_adv)
        begin
            regs_next = eff;
        end
        else
        begin
            regs_next = regs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg      <= '0;
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ld_reg     <= 1'b0;
            s1_sel_reg    <= '0;
            s1_fault_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
            if (clearing_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (&clear_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_ld_reg    <= req.rd_en;
                s1_sel_reg   <= target_select;
                s1_fault_reg <= exec_fault;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                s1_ld_reg    <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                out_fault_reg <= s1_fault_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_state_reg <= eff;
        end
    end

    assign out_valid   = out_valid_reg;
    assign instr_value = out_state_reg.instr;
    assign a_value     = out_state_reg.a;
    assign b_value     = out_state_reg.b;
    assign addr_low    = out_state_reg.addr_lo;
    assign addr_high   = out_state_reg.addr_hi;
    assign flag_bits   = out_state_reg.flags;
    assign pc_value    = out_state_reg.pc;
    assign step_value  = out_state_reg.step;
    assign port_zero   = out_state_reg.port0;
    assign port_one    = out_state_reg.port1;
    assign fault       = out_fault_reg;

    a_ld_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ld_reg |-> s1_valid_reg)
        else $error("Load pending without a transaction in flight.");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("Accepted transaction did not enter the read stage.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> ($stable(regs_reg) && $stable(s1_fault_reg)
                                       && $stable(s1_ld_reg)))
        else $error("Register state changed while the read stage was stalled.");

    a_no_access_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !ram_re))
        else $error("RAM accessed by a transaction during the clearing pass.");

endmodule

// ===== dv/tb_microop_execute_unit.sv =====
// Self-checking testbench for microop_execute_unit with a cycle-free state predictor.
module tb_microop_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic       EDGE_FALL    = 1'b0;
    localparam logic       EDGE_RISE    = 1'b1;
    localparam logic       STEP_CLEAR   = 1'b0;
    localparam logic       STEP_COUNT   = 1'b1;
    localparam logic [2:0] SEL_BAD_LO   = 3'd5;
    localparam logic [2:0] SEL_BAD_HI   = 3'd7;
    localparam logic [4:0] OP_UNUSED_LO = 5'd22;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    typedef struct {
        logic [7:0]  instr;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  alo;
        logic [7:0]  ahi;
        logic [1:0]  flags;
        logic [15:0] pc;
        logic [7:0]  step;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic        flt;
    } cpu_view_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        edge_req;
    logic [4:0]  micro_op;
    logic [2:0]  target_select;
    logic        step_keep;
    logic [7:0]  rom_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  instr_value;
    logic [7:0]  a_value;
    logic [7:0]  b_value;
    logic [7:0]  addr_low;
    logic [7:0]  addr_high;
    logic [1:0]  flag_bits;
    logic [15:0] pc_value;
    logic [7:0]  step_value;
    logic [7:0]  port_zero;
    logic [7:0]  port_one;
    logic        fault;

    cpu_view_t   cpu;
    bit [7:0]    ram_img [mxu_pkg::RAM_DEPTH];
    cpu_view_t   pending_views[$];
    int          fail_count;
    int          idle_cycles;
    int          rx_hold;
    int          rx_gap;
    bit          rx_quiet;
    bit          tx_quiet;

    microop_execute_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .edge_req      (edge_req),
        .micro_op      (micro_op),
        .target_select (target_select),
        .step_keep     (step_keep),
        .rom_byte      (rom_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .instr_value   (instr_value),
        .a_value       (a_value),
        .b_value       (b_value),
        .addr_low      (addr_low),
        .addr_high     (addr_high),
        .flag_bits     (flag_bits),
        .pc_value      (pc_value),
        .step_value    (step_value),
        .port_zero     (port_zero),
        .port_one      (port_one),
        .fault         (fault)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic put_reg(inout cpu_view_t v, input logic [2:0] sel, input logic [7:0] val);
        case (sel)
            mxu_pkg::SEL_INSTR:   v.instr = val;
            mxu_pkg::SEL_A:       v.a     = val;
            mxu_pkg::SEL_B:       v.b     = val;
            mxu_pkg::SEL_ADDR_LO: v.alo   = val;
            mxu_pkg::SEL_ADDR_HI: v.ahi   = val;
            default:     ;
        endcase
    endtask

    task automatic exec_micro_op(input logic e, input logic [4:0] op, input logic [2:0] sel,
                                 input logic keep, input logic [7:0] rom);
        cpu_view_t   nxt;
        logic [8:0]  sum;
        logic [7:0]  val;
        int unsigned addr;
        logic        writes_reg;
        nxt = cpu;
        nxt.flt = 1'b0;
        addr = {cpu.ahi, cpu.alo} % mxu_pkg::RAM_DEPTH;
        if (e == EDGE_RISE)
        begin
            nxt.step = (keep == STEP_COUNT) ? cpu.step + 8'd1 : 8'd0;
            if (op == mxu_pkg::OP_IMM || op == mxu_pkg::OP_STI || op == mxu_pkg::OP_OUTI)
                nxt.pc = cpu.pc + 16'd1;
            else if (op == mxu_pkg::OP_B)
                nxt.pc = {cpu.ahi, cpu.alo};
        end
        else
        begin
            writes_reg = (op >= mxu_pkg::OP_IMM && op <= mxu_pkg::OP_NOTB)
                         || op == mxu_pkg::OP_LD;
            if (writes_reg && sel > mxu_pkg::SEL_ADDR_HI)
                nxt.flt = 1'b1;
            else
            begin
                case (op)
                    mxu_pkg::OP_IMM:  put_reg(nxt, sel, rom);
                    mxu_pkg::OP_MOVA: put_reg(nxt, sel, cpu.a);
                    mxu_pkg::OP_MOVB: put_reg(nxt, sel, cpu.b);
                    mxu_pkg::OP_ADD, mxu_pkg::OP_ADDC, mxu_pkg::OP_SUB, mxu_pkg::OP_SUBC,
                    mxu_pkg::OP_CMP:
                    begin
                        case (op)
                            mxu_pkg::OP_ADD:  sum = {1'b0, cpu.a} + {1'b0, cpu.b};
                            mxu_pkg::OP_ADDC: sum = {1'b0, cpu.a} + {1'b0, cpu.b} + 9'd1;
                            mxu_pkg::OP_SUBC: sum = {1'b0, cpu.a} + {1'b0, ~cpu.b};
                            default: sum = {1'b0, cpu.a} + {1'b0, ~cpu.b} + 9'd1;
                        endcase
                        if (op != mxu_pkg::OP_CMP)
                            put_reg(nxt, sel, sum[7:0]);
                        nxt.flags = {sum[7:0] == 8'd0, ~sum[8]};
                    end
                    mxu_pkg::OP_AND, mxu_pkg::OP_OR, mxu_pkg::OP_XOR, mxu_pkg::OP_SHL,
                    mxu_pkg::OP_SHLC, mxu_pkg::OP_NOTA, mxu_pkg::OP_NOTB:
                    begin
                        case (op)
                            mxu_pkg::OP_AND:  val = cpu.a & cpu.b;
                            mxu_pkg::OP_OR:   val = cpu.a | cpu.b;
                            mxu_pkg::OP_XOR:  val = cpu.a ^ cpu.b;
                            mxu_pkg::OP_SHL:  val = {cpu.a[6:0], 1'b0};
                            mxu_pkg::OP_SHLC: val = {cpu.a[6:0], cpu.flags[0]};
                            mxu_pkg::OP_NOTA: val = ~cpu.a;
                            default: val = ~cpu.b;
                        endcase
                        put_reg(nxt, sel, val);
                        nxt.flags = mxu_pkg::FLAGS_LOGIC;
                    end
                    mxu_pkg::OP_STA:
                    begin
                        ram_img[addr] = cpu.a;
                        nxt.flags = mxu_pkg::FLAGS_LOGIC;
                    end
                    mxu_pkg::OP_STB:
                    begin
                        ram_img[addr] = cpu.b;
                        nxt.flags = mxu_pkg::FLAGS_LOGIC;
                    end
                    mxu_pkg::OP_STI:  ram_img[addr] = rom;
                    mxu_pkg::OP_LD:   put_reg(nxt, sel, ram_img[addr]);
                    mxu_pkg::OP_OUTI:
                    begin
                        if (cpu.alo == mxu_pkg::PORT_ZERO)
                            nxt.p0 = rom;
                        else if (cpu.alo == mxu_pkg::PORT_ONE)
                            nxt.p1 = rom;
                        else
                            nxt.flt = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        pending_views.push_back(nxt);
        cpu = nxt;
    endtask

    task automatic send_op(input logic e, input logic [4:0] op, input logic [2:0] sel,
                           input logic keep, input logic [7:0] rom);
        @(negedge clk);
        in_valid      <= 1'b1;
        edge_req      <= e;
        micro_op      <= op;
        target_select <= sel;
        step_keep     <= keep;
        rom_byte      <= rom;
        do
            @(posedge clk);
        while (!in_ready);
        exec_micro_op(e, op, sel, keep, rom);
    endtask

    task automatic idle_tx(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_results_done();
        idle_tx(1);
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_op();
        logic       e;
        logic [4:0] op;
        logic [2:0] sel;
        logic       keep;
        logic [7:0] rom;
        e    = 1'($urandom_range(0, 1));
        op   = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                                           : 5'($urandom_range(mxu_pkg::OP_NOP,
                                                                mxu_pkg::OP_OUTI));
        sel  = ($urandom_range(0, 99) < 10) ? 3'($urandom_range(SEL_BAD_LO, SEL_BAD_HI))
                                            : 3'($urandom_range(mxu_pkg::SEL_INSTR,
                                                                 mxu_pkg::SEL_ADDR_HI));
        keep = ($urandom_range(0, 99) < 90) ? STEP_COUNT : STEP_CLEAR;
        rom  = 8'($urandom_range(0, 255));
        // Keep addresses in a small window so stores, loads and port writes meet.
        if (op == mxu_pkg::OP_IMM && (sel == mxu_pkg::SEL_ADDR_LO || sel == mxu_pkg::SEL_ADDR_HI)
            && $urandom_range(0, 99) < 70)
            rom = 8'($urandom_range(0, 3));
        send_op(e, op, sel, keep, rom);
    endtask

    task automatic test_alu_ops();
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_A,       STEP_COUNT, 8'hFF);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_B,       STEP_COUNT, 8'h01);
        send_op(EDGE_FALL, mxu_pkg::OP_ADD,  mxu_pkg::SEL_A,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_SHLC, mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_ADDC, mxu_pkg::SEL_B,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_SUB,  mxu_pkg::SEL_ADDR_LO, STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_SUBC, mxu_pkg::SEL_ADDR_HI, STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_CMP,  SEL_BAD_HI,           STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_AND,  mxu_pkg::SEL_A,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_OR,   mxu_pkg::SEL_B,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_XOR,  mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_SHL,  mxu_pkg::SEL_A,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_NOTA, mxu_pkg::SEL_B,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_NOTB, mxu_pkg::SEL_A,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  SEL_BAD_LO,           STEP_COUNT, 8'h5A);
        send_op(EDGE_FALL, mxu_pkg::OP_MOVA, SEL_BAD_HI,           STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_MOVB, mxu_pkg::SEL_ADDR_LO, STEP_COUNT, 8'h00);
    endtask

    task automatic test_mem_port_branch();
        send_op(EDGE_FALL, mxu_pkg::OP_STA,  mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_STB,  mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_STI,  mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'hC3);
        send_op(EDGE_FALL, mxu_pkg::OP_LD,   mxu_pkg::SEL_B,       STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_OUTI, mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h77);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_ADDR_LO, STEP_COUNT,
                mxu_pkg::PORT_ZERO);
        send_op(EDGE_FALL, mxu_pkg::OP_OUTI, mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'hFF);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_ADDR_LO, STEP_COUNT,
                mxu_pkg::PORT_ONE);
        send_op(EDGE_FALL, mxu_pkg::OP_OUTI, mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_RISE, mxu_pkg::OP_IMM,  SEL_BAD_HI,           STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_ADDR_HI, STEP_COUNT, 8'hFF);
        send_op(EDGE_FALL, mxu_pkg::OP_IMM,  mxu_pkg::SEL_ADDR_LO, STEP_COUNT, 8'hFF);
        send_op(EDGE_RISE, mxu_pkg::OP_B,    mxu_pkg::SEL_INSTR,   STEP_CLEAR, 8'h00);
        send_op(EDGE_RISE, mxu_pkg::OP_OUTI, mxu_pkg::SEL_INSTR,   STEP_COUNT, 8'h00);
        send_op(EDGE_FALL, OP_UNUSED_HI,     mxu_pkg::SEL_A,       STEP_COUNT, 8'hFF);
        send_op(EDGE_RISE, OP_UNUSED_LO,     mxu_pkg::SEL_A,       STEP_COUNT, 8'hFF);
    endtask

    task automatic test_step_wrap();
        repeat (270)
            send_op(EDGE_RISE, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                    STEP_COUNT, 8'($urandom_range(0, 255)));
        send_op(EDGE_RISE, mxu_pkg::OP_NOP, mxu_pkg::SEL_INSTR, STEP_CLEAR, 8'h00);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n)
        begin
            send_random_op();
            if (!tx_quiet)
                idle_tx(pick_gap());
        end
    endtask

    task automatic test_streaming(input int n);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        test_random_mix(n);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        repeat (40)
            send_random_op();
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        cpu_view_t want;
        if (out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result transaction with no expected result at %0t", $realtime);
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("instr_value", 16'(want.instr), 16'(instr_value));
                check_field("a_value",     16'(want.a),     16'(a_value));
                check_field("b_value",     16'(want.b),     16'(b_value));
                check_field("addr_low",    16'(want.alo),   16'(addr_low));
                check_field("addr_high",   16'(want.ahi),   16'(addr_high));
                check_field("flag_bits",   16'(want.flags), 16'(flag_bits));
                check_field("pc_value",    want.pc,         pc_value);
                check_field("step_value",  16'(want.step),  16'(step_value));
                check_field("port_zero",   16'(want.p0),    16'(port_zero));
                check_field("port_one",    16'(want.p1),    16'(port_one));
                check_field("fault",       16'(want.flt),   16'(fault));
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_quiet)
                    rx_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        cpu           = '{default: '0};
        fail_count    = 0;
        idle_cycles   = 0;
        rx_hold       = 0;
        rx_gap        = 0;
        rx_quiet      = 1'b0;
        tx_quiet      = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        edge_req      = EDGE_FALL;
        micro_op      = mxu_pkg::OP_NOP;
        target_select = mxu_pkg::SEL_INSTR;
        step_keep     = STEP_CLEAR;
        rom_byte      = 8'h00;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_alu_ops();
        test_mem_port_branch();
        wait_results_done();
        test_step_wrap();
        test_random_mix(800);
        wait_results_done();
        test_streaming(300);
        test_backpressure();
        wait_results_done();
        test_random_mix(500);

        wait_results_done();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== microop_execute_unit.f =====
sv/mxu_pkg.sv
sv/mxu_ram.sv
sv/mxu_exec.sv
sv/microop_execute_unit.sv
dv/tb_microop_execute_unit.sv
